FILE: hdl/sedf_pkg.sv
// ----------------------------------------------------------------------------
// sedf_pkg
// Shared constants, types and codes for the start/end framed packet deframer.
// ----------------------------------------------------------------------------
package sedf_pkg;

  localparam int SLOT_COUNT  = 4;
  localparam int SLOT_BYTES  = 256;
  localparam int CHECK_BYTES = 2;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int POS_W   = $clog2(SLOT_BYTES);
  localparam int SIZE_W  = POS_W + 1;
  localparam int ADDR_W  = SLOT_W + POS_W;
  localparam int LEN_W   = 16;
  localparam int CHECK_W = 8;

  localparam logic [CHECK_W-1:0] CHECK_MAX = {CHECK_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_FINAL = 2'd2;

  localparam logic [7:0] START_RST = 8'd2;
  localparam logic [7:0] END_RST   = 8'd3;
  localparam logic [7:0] FINAL_RST = 8'd4;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_STORED   = 3'd1,
    EV_COMPLETE = 3'd2,
    EV_ABORT    = 3'd3,
    EV_READBACK = 3'd4
  } event_e;

  typedef enum logic {
    KIND_RX   = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  // pos is the store position, or the read position for a readback
  typedef struct packed {
    event_e              ev;
    logic [SLOT_W-1:0]   slot;
    logic [POS_W-1:0]    pos;
    logic [SIZE_W-1:0]   size;
    logic [7:0]          data;
  } cmd_t;

endpackage

FILE: hdl/sedf_front.sv
// ----------------------------------------------------------------------------
// sedf_front
// Accepts items, tracks framing state and turns each item into a command.
// ----------------------------------------------------------------------------
module sedf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic                full_i,
  output logic                push_o,
  input  logic                kind_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [1:0]          read_slot_i,
  input  logic [7:0]          read_pos_i,
  input  logic [7:0]          start_byte_i,
  input  logic [7:0]          end_byte_i,
  input  logic [7:0]          final_byte_i,
  output sedf_pkg::cmd_t      cmd_o
);

  logic                            in_frame_q, in_frame_d;
  logic                            end_seen_q, end_seen_d;
  logic [sedf_pkg::POS_W-1:0]      count_q, count_d;
  logic [sedf_pkg::CHECK_W-1:0]    check_q, check_d;
  logic [sedf_pkg::LEN_W-1:0]      len_q, len_d;
  logic [7:0]                      len_hi_q, len_hi_d;
  logic [sedf_pkg::SLOT_W-1:0]     head_q, head_d;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    logic                          open_frame;
    logic                          eff_end;
    logic [sedf_pkg::CHECK_W-1:0]  eff_check;
    logic [sedf_pkg::LEN_W-1:0]    eff_len;
    logic [sedf_pkg::POS_W-1:0]    pos;
    logic                          fin;
    open_frame = !in_frame_q && (rx_byte_i == start_byte_i);
    eff_end    = open_frame ? 1'b0 : end_seen_q;
    eff_check  = open_frame ? '0 : check_q;
    eff_len    = open_frame ? '0 : len_q;
    pos        = open_frame ? '0 : count_q;
    fin        = eff_end && (eff_check == sedf_pkg::CHECK_W'(sedf_pkg::CHECK_BYTES))
                 && (rx_byte_i == final_byte_i);

    in_frame_d = in_frame_q;
    end_seen_d = end_seen_q;
    count_d    = count_q;
    check_d    = check_q;
    len_d      = len_q;
    len_hi_d   = len_hi_q;
    head_d     = head_q;
    cmd_o      = '0;
    cmd_o.ev   = sedf_pkg::EV_IGNORED;

    if (kind_i == sedf_pkg::KIND_READ) begin
      cmd_o.ev   = sedf_pkg::EV_READBACK;
      cmd_o.slot = read_slot_i[sedf_pkg::SLOT_W-1:0];
      cmd_o.pos  = read_pos_i[sedf_pkg::POS_W-1:0];
    end else if (in_frame_q || open_frame) begin
      cmd_o.slot = head_q;
      cmd_o.pos  = pos;
      cmd_o.data = rx_byte_i;
      check_d    = (eff_end && eff_check != sedf_pkg::CHECK_MAX) ?
                   eff_check + sedf_pkg::CHECK_W'(1) : eff_check;
      end_seen_d = eff_end || ((rx_byte_i == end_byte_i) &&
                   (sedf_pkg::LEN_W'(pos) + sedf_pkg::LEN_W'(1) == eff_len));
      len_hi_d   = (pos == sedf_pkg::POS_W'(2)) ? rx_byte_i : len_hi_q;
      len_d      = (pos == sedf_pkg::POS_W'(3)) ? {len_hi_q, rx_byte_i} : eff_len;
      if (fin) begin
        cmd_o.ev   = sedf_pkg::EV_COMPLETE;
        cmd_o.size = sedf_pkg::SIZE_W'(pos) + sedf_pkg::SIZE_W'(1);
        in_frame_d = 1'b0;
        count_d    = '0;
        head_d     = (head_q == sedf_pkg::SLOT_W'(sedf_pkg::SLOT_COUNT - 1)) ?
                     '0 : head_q + sedf_pkg::SLOT_W'(1);
      end else if (pos == sedf_pkg::POS_W'(sedf_pkg::SLOT_BYTES - 1)) begin
        cmd_o.ev   = sedf_pkg::EV_ABORT;
        in_frame_d = 1'b0;
        count_d    = '0;
      end else begin
        cmd_o.ev   = sedf_pkg::EV_STORED;
        in_frame_d = 1'b1;
        count_d    = pos + sedf_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      end_seen_q <= 1'b0;
      count_q    <= '0;
      check_q    <= '0;
      len_q      <= '0;
      len_hi_q   <= '0;
      head_q     <= '0;
    end else if (push_o) begin
      in_frame_q <= in_frame_d;
      end_seen_q <= end_seen_d;
      count_q    <= count_d;
      check_q    <= check_d;
      len_q      <= len_d;
      len_hi_q   <= len_hi_d;
      head_q     <= head_d;
    end
  end

  a_complete_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd_o.ev == sedf_pkg::EV_COMPLETE) |=> !in_frame_q)
    else $error("frame still open after completion");

  a_check_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (check_q != '0) |-> end_seen_q)
    else $error("check count running without end byte");

  a_head_on_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && cmd_o.ev == sedf_pkg::EV_COMPLETE) |=> $stable(head_q))
    else $error("head slot moved without completion");

endmodule

FILE: hdl/sedf_queue.sv
// ----------------------------------------------------------------------------
// sedf_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module sedf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sedf_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sedf_pkg::cmd_t  cmd_o
);

  sedf_pkg::cmd_t                mem_q [sedf_pkg::QUEUE_DEPTH];
  logic [sedf_pkg::QPTR_W-1:0]   wr_q, wr_d;
  logic [sedf_pkg::QPTR_W-1:0]   rd_q, rd_d;
  logic [sedf_pkg::QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == sedf_pkg::QCNT_W'(sedf_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == sedf_pkg::QPTR_W'(sedf_pkg::QUEUE_DEPTH - 1)) ?
             '0 : wr_q + sedf_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == sedf_pkg::QPTR_W'(sedf_pkg::QUEUE_DEPTH - 1)) ?
             '0 : rd_q + sedf_pkg::QPTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + sedf_pkg::QCNT_W'(1);
      2'b01:   count_d = count_q - sedf_pkg::QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sedf_pkg::QCNT_W'(sedf_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty queue");

endmodule

FILE: hdl/sedf_back.sv
// ----------------------------------------------------------------------------
// sedf_back
// Executes commands on the packet and size stores and holds the result.
// ----------------------------------------------------------------------------
module sedf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  sedf_pkg::cmd_t               cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sedf_pkg::event_e             event_o,
  output logic [1:0]                   slot_o,
  output logic [7:0]                   position_o,
  output logic [8:0]                   frame_size_o,
  output logic [7:0]                   read_data_o,
  output logic [8:0]                   read_size_o
);

  localparam int MEM_DEPTH = sedf_pkg::SLOT_COUNT * sedf_pkg::SLOT_BYTES;

  logic [7:0]                  pkt_mem [MEM_DEPTH];
  logic [sedf_pkg::SIZE_W-1:0] size_mem [sedf_pkg::SLOT_COUNT];
  logic [7:0]                  rd_data_q;
  logic [sedf_pkg::SIZE_W-1:0] rd_size_q;
  logic                        out_valid_q, out_valid_d;
  sedf_pkg::cmd_t              cmd_q;
  logic [sedf_pkg::ADDR_W-1:0] addr;
  logic                        is_write;
  logic                        is_read;

  assign pop_o    = valid_i && (!out_valid_q || out_ready_i);
  assign addr     = {cmd_i.slot, cmd_i.pos};
  assign is_read  = (cmd_i.ev == sedf_pkg::EV_READBACK);
  assign is_write = (cmd_i.ev == sedf_pkg::EV_STORED) ||
                    (cmd_i.ev == sedf_pkg::EV_COMPLETE) ||
                    (cmd_i.ev == sedf_pkg::EV_ABORT);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_write) begin
      pkt_mem[addr] <= cmd_i.data;
    end
    if (pop_o && is_read) begin
      rd_data_q <= pkt_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.ev == sedf_pkg::EV_COMPLETE) begin
      size_mem[cmd_i.slot] <= cmd_i.size;
    end
    if (pop_o && is_read) begin
      rd_size_q <= size_mem[cmd_i.slot];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_o      = cmd_q.ev;
  assign slot_o       = 2'(cmd_q.slot);
  assign position_o   = (cmd_q.ev == sedf_pkg::EV_READBACK) ? '0 : 8'(cmd_q.pos);
  assign frame_size_o = (cmd_q.ev == sedf_pkg::EV_COMPLETE) ? 9'(cmd_q.size) : '0;
  assign read_data_o  = (cmd_q.ev == sedf_pkg::EV_READBACK) ? rd_data_q : '0;
  assign read_size_o  = (cmd_q.ev == sedf_pkg::EV_READBACK) ? 9'(rd_size_q) : '0;

endmodule

FILE: hdl/stx_etx_packet_deframer.sv
// ----------------------------------------------------------------------------
// stx_etx_packet_deframer
// Start/end framed serial packet receiver with a ring of slot buffers.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel: tuser is the kind (receive a byte or
// read back), tdata carries rx_byte, read_slot and read_pos. Each item gives
// exactly one result item on the m_ channel: tuser holds the event code,
// tdata the slot, position, frame size, read data and recorded slot size.
// The front tracks framing state and turns an item into a command in the
// cycle it is accepted; a two-entry queue feeds the back part, which does
// the packet store access and registers the result.
// The back part registers each queued command's result and raises m_tvalid.
// One item per cycle is sustained while m_tready stays high; the single-port
// packet memory, taking one write or one read per item, sets that figure.
// Start, end and final byte values are set over the APB port at addresses
// 0x0, 0x4 and 0x8; the user must write them only while the block is idle,
// as the block itself does not enforce it. Reset returns to the out-of-frame
// state with head slot 0 and the byte values 2, 3 and 4; store contents are
// undefined until written. When the receiver stalls, the result register
// holds, the queue fills and s_tready drops after two more items.
// ----------------------------------------------------------------------------
module stx_etx_packet_deframer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  input  logic [23:0]                        s_tdata_i,  // rx_byte, read_slot, read_pos
  input  logic                               s_tuser_i,  // kind
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [39:0]                        m_tdata_o,  // slot, position, frame_size,
                                                         // read_data, read_size
  output logic [2:0]                         m_tuser_o,  // event_res
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sedf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [7:0]          start_q;
  logic [7:0]          end_q;
  logic [7:0]          final_q;
  logic [1:0]          reg_idx;
  logic                cfg_wr;
  logic                q_full;
  logic                push;
  logic                pop;
  logic                q_valid;
  sedf_pkg::cmd_t      cmd_front;
  sedf_pkg::cmd_t      cmd_back;
  sedf_pkg::event_e    ev;
  logic [1:0]          slot;
  logic [7:0]          position;
  logic [8:0]          frame_size;
  logic [7:0]          read_data;
  logic [8:0]          read_size;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= sedf_pkg::START_RST;
      end_q   <= sedf_pkg::END_RST;
      final_q <= sedf_pkg::FINAL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        sedf_pkg::REG_START: start_q <= pwdata[7:0];
        sedf_pkg::REG_END:   end_q   <= pwdata[7:0];
        sedf_pkg::REG_FINAL: final_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sedf_pkg::REG_START: prdata = {24'd0, start_q};
      sedf_pkg::REG_END:   prdata = {24'd0, end_q};
      sedf_pkg::REG_FINAL: prdata = {24'd0, final_q};
      default:             prdata = '0;
    endcase
  end

  sedf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_tvalid_i),
    .ready_o      (s_tready_o),
    .full_i       (q_full),
    .push_o       (push),
    .kind_i       (s_tuser_i),
    .rx_byte_i    (s_tdata_i[7:0]),
    .read_slot_i  (s_tdata_i[9:8]),
    .read_pos_i   (s_tdata_i[17:10]),
    .start_byte_i (start_q),
    .end_byte_i   (end_q),
    .final_byte_i (final_q),
    .cmd_o        (cmd_front)
  );

  sedf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_front),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_back)
  );

  sedf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .cmd_i        (cmd_back),
    .pop_o        (pop),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .event_o      (ev),
    .slot_o       (slot),
    .position_o   (position),
    .frame_size_o (frame_size),
    .read_data_o  (read_data),
    .read_size_o  (read_size)
  );

  assign m_tuser_o = ev;
  assign m_tdata_o = {4'd0, read_size, read_data, frame_size, position, slot};

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the start/end framed packet deframer.
// ----------------------------------------------------------------------------
// Byte and readback items are queued by a stimulus process and put on the
// s_ stream by a clocked driver. Each accepted item runs through a software
// copy of the framing state and slot store. The monitor compares every
// result item field by field with the oldest prediction. Framing bytes are
// set over APB in several phases, while the block is idle. Both stream sides
// stall at random, apart from one steady window.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 425;
  localparam int IDLE_PERCENT = 23;

  typedef struct packed {
    sedf_pkg::kind_e  kind;
    logic [7:0]       rx_byte;
    logic [1:0]       read_slot;
    logic [7:0]       read_pos;
  } in_item_t;

  typedef struct packed {
    sedf_pkg::event_e              ev;
    logic [sedf_pkg::SLOT_W-1:0]   slot;
    logic [sedf_pkg::POS_W-1:0]    position;
    logic [sedf_pkg::SIZE_W-1:0]   frame_size;
    logic [7:0]                    read_data;
    logic [sedf_pkg::SIZE_W-1:0]   read_size;
  } result_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_ZERO_LEN,
    FRAME_BAD_END,
    FRAME_BAD_FINAL
  } frame_flaw_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i = '0;   // rx_byte, read_slot, read_pos
  logic        s_tuser_i = sedf_pkg::KIND_RX;  // kind
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [39:0] m_tdata_o;        // slot, position, frame_size, read_data, read_size
  logic [2:0]  m_tuser_o;        // event_res
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [sedf_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stx_etx_packet_deframer DUT (
    .clk_i, .rst_ni,
    .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tuser_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t stream_items[$];
  result_t  pending_results[$];
  in_item_t cur_item;
  logic     in_taken = 1'b0;
  int       cycle = 0;
  int       fail_count = 0;
  int       stim_count = 0;
  logic     steady;

  assign steady = (cycle >= 1000) && (cycle < 1800);

  // shadow of the block's configuration and framing state
  logic [7:0]                    cfg_start = sedf_pkg::START_RST;
  logic [7:0]                    cfg_end   = sedf_pkg::END_RST;
  logic [7:0]                    cfg_final = sedf_pkg::FINAL_RST;
  logic                          frame_open = 1'b0;
  logic                          end_mark = 1'b0;
  logic                          final_mark = 1'b0;
  logic [sedf_pkg::SIZE_W-1:0]   byte_cnt = '0;
  logic [sedf_pkg::CHECK_W-1:0]  check_cnt = '0;
  logic [sedf_pkg::LEN_W-1:0]    frame_len = '0;
  logic [sedf_pkg::SLOT_W-1:0]   head = '0;
  logic [7:0]                    slot_mem [sedf_pkg::SLOT_COUNT][sedf_pkg::SLOT_BYTES];
  bit                            byte_valid [sedf_pkg::SLOT_COUNT][sedf_pkg::SLOT_BYTES];
  logic [sedf_pkg::SIZE_W-1:0]   size_mem [sedf_pkg::SLOT_COUNT];
  bit [sedf_pkg::SLOT_COUNT-1:0] size_valid = '0;

  function automatic result_t deframer_outcome(input in_item_t it);
    result_t                     r;
    logic [sedf_pkg::SLOT_W-1:0] hs;
    logic [sedf_pkg::POS_W-1:0]  pos;
    logic [7:0]                  b;
    r = '0;
    b = it.rx_byte;
    if (it.kind == sedf_pkg::KIND_READ) begin
      r.ev        = sedf_pkg::EV_READBACK;
      r.slot      = it.read_slot;
      r.read_data = slot_mem[it.read_slot][it.read_pos];
      r.read_size = size_mem[it.read_slot];
      return r;
    end
    if (b == cfg_start && !frame_open) begin
      byte_cnt   = '0;
      check_cnt  = '0;
      frame_len  = '0;
      frame_open = 1'b1;
      end_mark   = 1'b0;
      final_mark = 1'b0;
    end
    if (!frame_open) return r;
    if (end_mark) begin
      if (check_cnt == sedf_pkg::CHECK_BYTES && b == cfg_final) final_mark = 1'b1;
      if (check_cnt != sedf_pkg::CHECK_MAX) check_cnt = check_cnt + 1'b1;
    end
    if (b == cfg_end && 16'(byte_cnt) + 16'd1 == frame_len) end_mark = 1'b1;
    hs  = head;
    pos = byte_cnt[sedf_pkg::POS_W-1:0];
    slot_mem[hs][pos]   = b;
    byte_valid[hs][pos] = 1'b1;
    byte_cnt = {1'b0, pos} + 1'b1;
    if (byte_cnt == 4) frame_len = {slot_mem[hs][2], slot_mem[hs][3]};
    r.ev       = sedf_pkg::EV_STORED;
    r.slot     = hs;
    r.position = pos;
    if (final_mark) begin
      frame_open     = 1'b0;
      size_mem[hs]   = byte_cnt;
      size_valid[hs] = 1'b1;
      head           = (int'(hs) == sedf_pkg::SLOT_COUNT - 1) ? '0 : hs + 1'b1;
      r.ev           = sedf_pkg::EV_COMPLETE;
      r.frame_size   = byte_cnt;
    end
    if (byte_cnt >= sedf_pkg::SLOT_BYTES) begin
      byte_cnt   = '0;
      frame_open = 1'b0;
      if (r.ev != sedf_pkg::EV_COMPLETE) r.ev = sedf_pkg::EV_ABORT;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else if (!s_tvalid_i || in_taken) begin
      if (stream_items.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        cur_item = stream_items.pop_front();
        s_tdata_i  <= {6'b0, cur_item.read_pos, cur_item.read_slot, cur_item.rx_byte};
        s_tuser_i  <= cur_item.kind;
        s_tvalid_i <= 1'b1;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
    m_tready_i <= rst_ni && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    in_taken <= rst_ni && s_tvalid_i && s_tready_o;
    if (rst_ni && s_tvalid_i && s_tready_o)
      pending_results.push_back(deframer_outcome(cur_item));
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res",  want.ev,         m_tuser_o);
        check_field("slot",       want.slot,       m_tdata_o[1:0]);
        check_field("position",   want.position,   m_tdata_o[9:2]);
        check_field("frame_size", want.frame_size, m_tdata_o[18:10]);
        check_field("read_data",  want.read_data,  m_tdata_o[26:19]);
        check_field("read_size",  want.read_size,  m_tdata_o[35:27]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t rx_item(input logic [7:0] b);
    in_item_t it;
    it.kind      = sedf_pkg::KIND_RX;
    it.rx_byte   = b;
    it.read_slot = 2'($urandom);
    it.read_pos  = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [1:0] s, input logic [7:0] p);
    in_item_t it;
    it.kind      = sedf_pkg::KIND_READ;
    it.rx_byte   = 8'($urandom);
    it.read_slot = s;
    it.read_pos  = p;
    return it;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == cfg_start) b = ~b;
    return b;
  endfunction

  task automatic enqueue(input in_item_t it, input bit counted);
    while (stream_items.size() >= 16) @(posedge clk_i);
    stream_items.push_back(it);
    if (counted) stim_count++;
  endtask

  // all queued items accepted and predicted
  task automatic settle();
    while (stream_items.size() != 0 || s_tvalid_i) @(posedge clk_i);
  endtask

  task automatic drain();
    settle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // only entries already written by accepted items are read
  task automatic push_read();
    int         s;
    int         tries;
    logic [7:0] p;
    if (size_valid == '0) return;
    do s = $urandom_range(0, sedf_pkg::SLOT_COUNT - 1); while (!size_valid[s]);
    p = 8'($urandom);
    for (tries = 0; tries < 40 && !byte_valid[s][p]; tries++) p = 8'($urandom);
    if (!byte_valid[s][p]) p = '0;
    enqueue(read_item(2'(s), p), 1'b1);
  endtask

  task automatic push_frame(input int len, input frame_flaw_e flaw);
    logic [15:0] len_field;
    logic [7:0]  b;
    int          total;
    int          p;
    len_field = (flaw == FRAME_ZERO_LEN) ? 16'd0 : 16'(len);
    total     = len + sedf_pkg::CHECK_BYTES + 1;
    for (p = 0; p < total; p++) begin
      if ($urandom_range(0, 99) < 8) push_read();
      b = 8'($urandom);
      if (p == 0) b = cfg_start;
      else if (p == 2) b = len_field[15:8];
      else if (p == 3) b = len_field[7:0];
      else if (p == len - 1)
        b = (flaw == FRAME_BAD_END) ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end;
      else if (p == total - 1)
        b = (flaw == FRAME_BAD_FINAL) ? cfg_final ^ 8'($urandom_range(1, 255)) : cfg_final;
      else if (p < len - 1 && $urandom_range(0, 19) == 0) b = cfg_start;
      enqueue(rx_item(b), 1'b1);
    end
    // a broken frame stays open until its slot fills
    if (flaw != FRAME_GOOD) begin
      settle();
      while (frame_open) begin
        for (p = 0; p < 8; p++) enqueue(rx_item(noise_byte()), 1'b1);
        settle();
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'b0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] s, input logic [7:0] e,
                               input logic [7:0] f);
    drain();
    write_reg(sedf_pkg::REG_START, s);
    write_reg(sedf_pkg::REG_END, e);
    write_reg(sedf_pkg::REG_FINAL, f);
    cfg_start = s;
    cfg_end   = e;
    cfg_final = f;
  endtask

  task automatic random_phase();
    int goal;
    int pick;
    int r;
    int len;
    goal = stim_count + PHASE_ITEMS;
    while (stim_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        r = $urandom_range(0, 299);
        // r == 0 completes on the last slot byte
        if (r == 0) len = sedf_pkg::SLOT_BYTES - sedf_pkg::CHECK_BYTES - 1;
        else if (r < 30) len = $urandom_range(17, 60);
        else len = $urandom_range(5, 16);
        push_frame(len, FRAME_GOOD);
      end else if (pick < 77) begin
        repeat ($urandom_range(1, 4)) push_read();
      end else if (pick < 98) begin
        repeat ($urandom_range(1, 4)) enqueue(rx_item(noise_byte()), 1'b0);
      end else begin
        r = $urandom_range(0, 2);
        push_frame($urandom_range(5, 12),
                   (r == 0) ? FRAME_ZERO_LEN : (r == 1) ? FRAME_BAD_END : FRAME_BAD_FINAL);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset byte values
    enqueue(rx_item(8'hFF), 1'b0);
    enqueue(rx_item(8'h00), 1'b0);
    // start byte inside the frame, check bytes equal to the final byte
    enqueue(rx_item(sedf_pkg::START_RST), 1'b1);
    enqueue(rx_item(8'hAA), 1'b1);
    enqueue(rx_item(8'h00), 1'b1);
    enqueue(rx_item(8'h06), 1'b1);
    enqueue(rx_item(sedf_pkg::START_RST), 1'b1);
    enqueue(rx_item(sedf_pkg::END_RST), 1'b1);
    enqueue(rx_item(sedf_pkg::FINAL_RST), 1'b1);
    enqueue(rx_item(sedf_pkg::FINAL_RST), 1'b1);
    enqueue(rx_item(sedf_pkg::FINAL_RST), 1'b1);
    enqueue(read_item(2'd0, 8'd0), 1'b1);
    enqueue(read_item(2'd0, 8'd8), 1'b1);
    enqueue(rx_item(sedf_pkg::START_RST), 1'b1);
    enqueue(rx_item(8'h55), 1'b1);
    enqueue(rx_item(8'h00), 1'b1);
    enqueue(rx_item(8'h05), 1'b1);
    enqueue(rx_item(sedf_pkg::END_RST), 1'b1);
    enqueue(rx_item(8'hFF), 1'b1);
    enqueue(rx_item(8'h00), 1'b1);
    enqueue(rx_item(sedf_pkg::FINAL_RST), 1'b1);
    enqueue(read_item(2'd1, 8'd4), 1'b1);
    enqueue(read_item(2'd0, 8'd2), 1'b1);

    random_phase();
    apply_setting(8'h00, 8'hFF, 8'h00);
    random_phase();
    apply_setting(8'hFF, 8'h00, 8'hFF);
    random_phase();
    apply_setting(8'($urandom), 8'($urandom), 8'($urandom));
    random_phase();

    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
